FILE: sv/cgf_pkg.sv
// Shared constants, types and helper functions of the Canny gradient front end.
package cgf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int BLUR_SIZE      = 5;
    localparam int RING_ROWS      = 8;
    localparam int RING_BITS      = 3;

    localparam int CFG_WIDTH      = 16;
    localparam int DIM_CFG_WIDTH  = 11;
    localparam int INDEX_WIDTH    = 4;
    localparam int NUM_WEIGHTS    = 6;

    // register indexes
    localparam logic [INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = 4'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_CENTER = 4'd2;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_D1     = 4'd3;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_D2     = 4'd4;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_D4     = 4'd5;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_D5     = 4'd6;
    localparam logic [INDEX_WIDTH-1:0] REG_GAUSS_D8     = 4'd7;

    // weight select codes, same order as the weight registers
    localparam logic [2:0] W_CENTER = 3'd0;
    localparam logic [2:0] W_D1     = 3'd1;
    localparam logic [2:0] W_D2     = 3'd2;
    localparam logic [2:0] W_D4     = 3'd3;
    localparam logic [2:0] W_D5     = 3'd4;
    localparam logic [2:0] W_D8     = 3'd5;

    localparam logic [DIM_CFG_WIDTH-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_CFG_WIDTH-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_CENTER = 16'd6127;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_D1     = 16'd4747;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_D2     = 16'd3679;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_D4     = 16'd2208;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_D5     = 16'd1711;
    localparam logic [CFG_WIDTH-1:0] RST_GAUSS_D8     = 16'd796;

    // Q0.16 luma weights
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // tan 22.5 and tan 67.5 degrees, 24 fraction bits
    localparam logic [25:0] TAN22_Q24 = 26'd6949350;
    localparam logic [25:0] TAN67_Q24 = 26'd40503782;

    localparam logic [1:0] DIR_0  = 2'd0;
    localparam logic [1:0] DIR_45 = 2'd1;
    localparam logic [1:0] DIR_90 = 2'd2;

    typedef logic [NUM_WEIGHTS-1:0][CFG_WIDTH-1:0] weights_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TAP,
        BK_DRAIN,
        BK_BLUR,
        BK_GRAD,
        BK_MUL,
        BK_SQRT,
        BK_OUT
    } bk_state_t;

    // weight code from tap offsets 0..4 (center at 2)
    function automatic logic [2:0] weight_sel(input logic [2:0] dx, input logic [2:0] dy);
        logic [2:0] ax;
        logic [2:0] ay;
        logic [3:0] d2;
        logic [2:0] code;
        ax = (dx >= 3'd2) ? dx - 3'd2 : 3'd2 - dx;
        ay = (dy >= 3'd2) ? dy - 3'd2 : 3'd2 - dy;
        d2 = 4'(ax * ax) + 4'(ay * ay);
        case (d2)
            4'd0:    code = W_CENTER;
            4'd1:    code = W_D1;
            4'd2:    code = W_D2;
            4'd4:    code = W_D4;
            4'd5:    code = W_D5;
            default: code = W_D8;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/cgf_fifo.sv
// Small register FIFO used for the job queue and the result queue.
module cgf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: sv/cgf_front.sv
// Input side: gray conversion, line store writes, frame counters and job issue.
module cgf_front
    import cgf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          opcode,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [DIM_CFG_WIDTH-1:0]      cfg_width,
    input  logic [DIM_CFG_WIDTH-1:0]      cfg_height,
    input  logic                          stall,
    output logic                          gray_we,
    output logic [RING_BITS+$clog2(MAX_WIDTH)-1:0] gray_addr,
    output logic [7:0]                    gray_data,
    output logic                          job_push,
    output logic [$clog2(MAX_HEIGHT+1)-1:0] job_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  job_col,
    output logic                          job_last,
    output logic [$clog2(MAX_WIDTH+1)-1:0] job_w,
    output logic [$clog2(MAX_HEIGHT+1)-1:0] job_h
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = $clog2(3 * MAX_WIDTH + 5);

    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [HW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [WW-1:0] lat_w_reg, lat_w_next;
    logic [HW-1:0] lat_h_reg, lat_h_next;
    logic [DW-1:0] lag_reg, lag_next;

    logic          accept, is_pixel, first, in_active, pix_wr, emit, out_last;
    logic [WW-1:0] clamp_w, w_use;
    logic [HW-1:0] clamp_h, h_use;
    logic [DW-1:0] lag_inc, thresh;
    logic [23:0]   luma;

    assign full     = stall;
    assign accept   = push && !full;
    assign is_pixel = (opcode == 1'b0);
    assign first    = is_pixel && in_row_reg == '0 && in_col_reg == '0
                      && out_row_reg == '0 && out_col_reg == '0;

    always_comb
    begin
        if (cfg_width == '0)
        begin
            clamp_w = WW'(1);
        end
        else if (32'(cfg_width) > MAX_WIDTH)
        begin
            clamp_w = WW'(MAX_WIDTH);
        end
        else
        begin
            clamp_w = WW'(cfg_width);
        end
        if (cfg_height == '0)
        begin
            clamp_h = HW'(1);
        end
        else if (32'(cfg_height) > MAX_HEIGHT)
        begin
            clamp_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            clamp_h = HW'(cfg_height);
        end
    end

    assign w_use     = first ? clamp_w : lat_w_reg;
    assign h_use     = first ? clamp_h : lat_h_reg;
    assign in_active = 32'(in_row_reg) < 32'(h_use);
    assign pix_wr    = accept && in_active && is_pixel;
    assign lag_inc   = lag_reg + DW'(1);
    assign thresh    = DW'(w_use) + (DW'(w_use) << 1) + DW'(3);
    assign out_last  = (32'(out_row_reg) == 32'(h_use) - 1)
                       && (32'(out_col_reg) == 32'(w_use) - 1);
    assign emit      = (pix_wr && lag_inc > thresh)
                       || (accept && !in_active && 32'(out_row_reg) < 32'(h_use));

    // luma: Q0.16 weights, truncated
    assign luma      = 24'(red * LUMA_R) + 24'(green * LUMA_G) + 24'(blue * LUMA_B);
    assign gray_we   = pix_wr;
    assign gray_addr = {in_row_reg[RING_BITS-1:0], in_col_reg};
    assign gray_data = luma[23:16];

    assign job_push  = emit;
    assign job_row   = out_row_reg;
    assign job_col   = out_col_reg;
    assign job_last  = out_last;
    assign job_w     = w_use;
    assign job_h     = h_use;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lag_next     = lag_reg;
        lat_w_next   = lat_w_reg;
        lat_h_next   = lat_h_reg;
        if (accept)
        begin
            lat_w_next = w_use;
            lat_h_next = h_use;
        end
        if (pix_wr)
        begin
            lag_next = lag_inc;
            if (32'(in_col_reg) + 1 >= 32'(w_use))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (emit)
        begin
            lag_next = lag_next - DW'(1);
            if (out_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                lag_next     = '0;
            end
            else if (32'(out_col_reg) + 1 >= 32'(w_use))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + HW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
            lat_w_reg   <= WW'(640);
            lat_h_reg   <= HW'(480);
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lag_reg     <= lag_next;
            lat_w_reg   <= lat_w_next;
            lat_h_reg   <= lat_h_next;
        end
    end

endmodule

FILE: sv/cgf_back.sv
// Compute side: gray line store, 5x5 blur over a shared MAC, Sobel, sqrt, direction.
module cgf_back
    import cgf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          gray_we,
    input  logic [RING_BITS+$clog2(MAX_WIDTH)-1:0] gray_addr,
    input  logic [7:0]                    gray_data,
    input  weights_t                      weights,
    input  logic                          job_valid,
    output logic                          job_pop,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] job_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]  job_col,
    input  logic                          job_last,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] job_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] job_h,
    output logic                          busy,
    input  logic                          res_full,
    output logic                          res_push,
    output logic [7:0]                    res_mag,
    output logic [1:0]                    res_dir,
    output logic                          res_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = ((HW > WW) ? HW : WW) + 3;
    localparam int AW = RING_BITS + CW;
    localparam int TAPS = BLUR_SIZE;

    logic [7:0] mem_reg [RING_ROWS << CW];
    logic [7:0] rd_data_reg;

    bk_state_t state_reg, state_next;

    logic [HW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic          last_reg;
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;

    logic [2:0]  dx_reg, dy_reg;
    logic [1:0]  bi_r_reg, bi_c_reg;
    logic        p1_valid_reg, p1_ok_reg, p2_valid_reg;
    logic [15:0] p1_w_reg;
    logic [23:0] prod_reg;
    logic [28:0] acc_reg;
    logic [8:0][7:0] blur_win_reg;
    logic [7:0]  gx_reg, gy_reg;
    logic [16:0] rem_reg;
    logic [17:0] root_reg;
    logic [16:0] bit_reg;
    logic [1:0]  dir_reg;

    logic signed [PW-1:0] br, bc, gr, gc;
    logic        blur_in, gray_in, tap_last, bi_last;
    logic [AW-1:0] rd_addr;
    logic [12:0] blur_sh;
    logic [7:0]  blur_val;
    logic signed [11:0] sx, sy;
    logic [17:0] trial;
    logic [31:0] lhs;

    // tap position in the frame
    assign br = $signed(PW'(row_reg)) + $signed(PW'(bi_r_reg)) - $signed(PW'(1));
    assign bc = $signed(PW'(col_reg)) + $signed(PW'(bi_c_reg)) - $signed(PW'(1));
    assign gr = br + $signed(PW'(dy_reg)) - $signed(PW'(2));
    assign gc = bc + $signed(PW'(dx_reg)) - $signed(PW'(2));
    assign blur_in = !br[PW-1] && !bc[PW-1]
                     && (br < $signed(PW'(h_reg))) && (bc < $signed(PW'(w_reg)));
    assign gray_in = !gr[PW-1] && !gc[PW-1]
                     && (gr < $signed(PW'(h_reg))) && (gc < $signed(PW'(w_reg)));
    assign rd_addr = {gr[RING_BITS-1:0], gc[CW-1:0]};
    assign tap_last = (dx_reg == 3'(TAPS - 1)) && (dy_reg == 3'(TAPS - 1));
    assign bi_last  = (bi_r_reg == 2'd2) && (bi_c_reg == 2'd2);

    assign blur_sh  = acc_reg[28:16];
    assign blur_val = (blur_sh > 13'd255) ? 8'd255 : blur_sh[7:0];

    // Sobel on the 3x3 blur window, row-major
    assign sx = (12'(blur_win_reg[0]) - 12'(blur_win_reg[2]))
              + ((12'(blur_win_reg[3]) - 12'(blur_win_reg[5])) <<< 1)
              + (12'(blur_win_reg[6]) - 12'(blur_win_reg[8]));
    assign sy = (12'(blur_win_reg[0]) + (12'(blur_win_reg[1]) << 1) + 12'(blur_win_reg[2]))
              - (12'(blur_win_reg[6]) + (12'(blur_win_reg[7]) << 1) + 12'(blur_win_reg[8]));

    assign trial = root_reg + 18'(bit_reg);
    assign lhs   = {gy_reg, 24'b0};

    // line store
    always_ff @(posedge clk)
    begin
        if (gray_we)
        begin
            mem_reg[gray_addr] <= gray_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (job_valid) state_next = BK_TAP;
            BK_TAP:   if (tap_last) state_next = BK_DRAIN;
            BK_DRAIN: if (!p1_valid_reg && !p2_valid_reg) state_next = BK_BLUR;
            BK_BLUR:  state_next = bi_last ? BK_GRAD : BK_TAP;
            BK_GRAD:  state_next = BK_MUL;
            BK_MUL:   state_next = BK_SQRT;
            BK_SQRT:  if (bit_reg[16:2] == '0) state_next = BK_OUT;
            BK_OUT:   if (!res_full) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop  = 1'b0;
        res_push = 1'b0;
        busy     = 1'b1;
        case (state_reg)
            BK_IDLE:
            begin
                job_pop = job_valid;
                busy    = 1'b0;
            end
            BK_OUT:   res_push = !res_full;
            default:  ;
        endcase
    end

    assign res_mag  = (root_reg > 18'd255) ? 8'd255 : root_reg[7:0];
    assign res_dir  = dir_reg;
    assign res_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= (state_reg == BK_TAP);
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ok_reg <= blur_in && gray_in;
        p1_w_reg  <= weights[weight_sel(dx_reg, dy_reg)];
        prod_reg  <= p1_ok_reg ? 24'(rd_data_reg * p1_w_reg) : '0;
        if (p2_valid_reg)
        begin
            acc_reg <= acc_reg + 29'(prod_reg);
        end
        case (state_reg)
            BK_IDLE:
            begin
                row_reg  <= job_row;
                col_reg  <= job_col;
                last_reg <= job_last;
                w_reg    <= job_w;
                h_reg    <= job_h;
                dx_reg   <= '0;
                dy_reg   <= '0;
                bi_r_reg <= '0;
                bi_c_reg <= '0;
                acc_reg  <= '0;
            end
            BK_TAP:
            begin
                if (dx_reg == 3'(TAPS - 1))
                begin
                    dx_reg <= '0;
                    dy_reg <= (dy_reg == 3'(TAPS - 1)) ? '0 : dy_reg + 3'd1;
                end
                else
                begin
                    dx_reg <= dx_reg + 3'd1;
                end
            end
            BK_BLUR:
            begin
                blur_win_reg[4'(bi_r_reg) * 4'd3 + 4'(bi_c_reg)] <= blur_val;
                acc_reg <= '0;
                if (bi_c_reg == 2'd2)
                begin
                    bi_c_reg <= '0;
                    bi_r_reg <= bi_r_reg + 2'd1;
                end
                else
                begin
                    bi_c_reg <= bi_c_reg + 2'd1;
                end
            end
            BK_GRAD:
            begin
                gx_reg <= sx[11] ? 8'd0 : ((sx > 12'sd255) ? 8'd255 : sx[7:0]);
                gy_reg <= sy[11] ? 8'd0 : ((sy > 12'sd255) ? 8'd255 : sy[7:0]);
            end
            BK_MUL:
            begin
                rem_reg  <= 17'(gx_reg * gx_reg) + 17'(gy_reg * gy_reg);
                root_reg <= '0;
                bit_reg  <= 17'h10000;
                if (34'(lhs) <= 34'(TAN22_Q24 * gx_reg))
                begin
                    dir_reg <= DIR_0;
                end
                else if (34'(lhs) <= 34'(TAN67_Q24 * gx_reg))
                begin
                    dir_reg <= DIR_45;
                end
                else
                begin
                    dir_reg <= DIR_90;
                end
            end
            BK_SQRT:
            begin
                // one result bit per cycle
                if (18'(rem_reg) >= trial)
                begin
                    rem_reg  <= rem_reg - 17'(trial);
                    root_reg <= (root_reg >> 1) + 18'(bit_reg);
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

endmodule

FILE: sv/canny_gradient_front_end.sv
// Top level of the Canny gradient front end: config registers, queues, front and back.
//
// Takes RGB pixels in raster order (push/full) and returns one gradient word
// per pixel (empty/pop): 8-bit magnitude, 2-bit direction code (0, 45, 90
// degrees) and a last-of-frame flag. Pixels become 8-bit luma (Q0.16 weights),
// are blurred by a zero-padded 5x5 Gaussian with six programmable weights, then
// run through 3x3 Sobel with clipped gradients. The first result of a frame comes
// out once 3*width+4 pixels are in; after the frame's last pixel, push flush
// words (opcode 1) to drain the remaining results, one per flush. Frame size is
// latched at the first pixel of each frame; weights apply to every result
// computed after the write. Rate: while no job is queued or being computed,
// pixels that produce no result are taken one per clock. A pixel or flush
// that produces a result starts one job on the compute side, which runs the
// 225 blur taps through a single shared multiply-accumulate with a registered
// line store read (nine blurs of 25 taps, each followed by a pipeline drain
// and a store), then Sobel, the squared sum and a 9-step bit serial square
// root; full stays high until the result is pushed to the result queue.
// Config writes must be made only while the block is idle; the block itself
// does not enforce this.
module canny_gradient_front_end
    import cgf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   opcode,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             magnitude,
    output logic [1:0]             direction,
    output logic                   last_of_frame,
    input  logic                   write_enable,
    input  logic [INDEX_WIDTH-1:0] reg_index,
    input  logic [CFG_WIDTH-1:0]   write_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int JW = HW + CW + 1 + WW + HW;
    localparam int RW = 8 + 2 + 1;

    logic [DIM_CFG_WIDTH-1:0] frame_width_reg, frame_height_reg;
    weights_t                 weights_reg;

    // config write port; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            weights_reg[W_CENTER] <= RST_GAUSS_CENTER;
            weights_reg[W_D1]     <= RST_GAUSS_D1;
            weights_reg[W_D2]     <= RST_GAUSS_D2;
            weights_reg[W_D4]     <= RST_GAUSS_D4;
            weights_reg[W_D5]     <= RST_GAUSS_D5;
            weights_reg[W_D8]     <= RST_GAUSS_D8;
        end
        else if (write_enable)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= write_data[DIM_CFG_WIDTH-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= write_data[DIM_CFG_WIDTH-1:0];
                REG_GAUSS_CENTER: weights_reg[W_CENTER] <= write_data;
                REG_GAUSS_D1:     weights_reg[W_D1]     <= write_data;
                REG_GAUSS_D2:     weights_reg[W_D2]     <= write_data;
                REG_GAUSS_D4:     weights_reg[W_D4]     <= write_data;
                REG_GAUSS_D5:     weights_reg[W_D5]     <= write_data;
                REG_GAUSS_D8:     weights_reg[W_D8]     <= write_data;
                default:          ;
            endcase
        end
    end

    logic                gray_we;
    logic [RING_BITS+CW-1:0] gray_addr;
    logic [7:0]          gray_data;
    logic                job_push, job_full, job_pop, job_empty, back_busy;
    logic [HW-1:0]       f_row, b_row, f_h, b_h;
    logic [CW-1:0]       f_col, b_col;
    logic                f_last, b_last;
    logic [WW-1:0]       f_w, b_w;
    logic                res_push, res_full;
    logic [7:0]          res_mag;
    logic [1:0]          res_dir;
    logic                res_last;

    // front holds while a job is queued or being computed
    cgf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cfg_width  (frame_width_reg),
        .cfg_height (frame_height_reg),
        .stall      (!job_empty || back_busy || job_full),
        .gray_we    (gray_we),
        .gray_addr  (gray_addr),
        .gray_data  (gray_data),
        .job_push   (job_push),
        .job_row    (f_row),
        .job_col    (f_col),
        .job_last   (f_last),
        .job_w      (f_w),
        .job_h      (f_h)
    );

    cgf_fifo #(
        .WIDTH (JW),
        .DEPTH (2)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data ({f_row, f_col, f_last, f_w, f_h}),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data ({b_row, b_col, b_last, b_w, b_h}),
        .empty   (job_empty)
    );

    cgf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gray_we   (gray_we),
        .gray_addr (gray_addr),
        .gray_data (gray_data),
        .weights   (weights_reg),
        .job_valid (!job_empty),
        .job_pop   (job_pop),
        .job_row   (b_row),
        .job_col   (b_col),
        .job_last  (b_last),
        .job_w     (b_w),
        .job_h     (b_h),
        .busy      (back_busy),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_mag   (res_mag),
        .res_dir   (res_dir),
        .res_last  (res_last)
    );

    // result words wait here; compute holds at its output only when this queue is full
    cgf_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data ({res_mag, res_dir, res_last}),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data ({magnitude, direction, last_of_frame}),
        .empty   (empty)
    );

endmodule

FILE: sim/canny_gradient_front_end_tb.sv
// Self-checking testbench for the Canny gradient front end.
`timescale 1ns / 1ps

module canny_gradient_front_end_tb;
    import cgf_pkg::*;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;
    localparam int   RING_ENTRIES = RING_ROWS * DEF_MAX_WIDTH;
    localparam int   STALL_LIMIT  = 20000;   // cycles with no word moving on either side
    localparam int   SETTLE_CYCLES = 300;    // a bit more than one result's compute time
    localparam int   HOLD_CYCLES  = 1500;    // long receiver hold-off, fills the block
    localparam int   RANDOM_WORDS = 300;

    typedef struct {
        logic [7:0] mag;
        logic [1:0] dir;
        logic       lof;
    } grad_word_t;

    // Scoreboard: its own copy of the pipeline state, plus the queue of gradient
    // words the block still owes us.
    class gradient_scoreboard;
        logic [15:0]  regs [8];
        logic [7:0]   gray_ring [RING_ENTRIES];
        int unsigned  col, row, outs, lat_w, lat_h;
        grad_word_t   owed_words [$];
        int           errors;
        int           words_in;
        int           words_out;
        int           flushes;

        function new();
            regs[0] = RST_FRAME_WIDTH;
            regs[1] = RST_FRAME_HEIGHT;
            regs[2] = RST_GAUSS_CENTER;
            regs[3] = RST_GAUSS_D1;
            regs[4] = RST_GAUSS_D2;
            regs[5] = RST_GAUSS_D4;
            regs[6] = RST_GAUSS_D5;
            regs[7] = RST_GAUSS_D8;
            foreach (gray_ring[i]) gray_ring[i] = '0;
            col = 0;
            row = 0;
            outs = 0;
            lat_w = clamp_dim(regs[0], DEF_MAX_WIDTH);
            lat_h = clamp_dim(regs[1], DEF_MAX_HEIGHT);
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(int unsigned idx, logic [15:0] v);
            if (idx < 2) regs[idx] = {5'd0, v[10:0]};
            else if (idx < 8) regs[idx] = v;
            // indexes above 7 are dropped
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(regs[0], DEF_MAX_WIDTH) * clamp_dim(regs[1], DEF_MAX_HEIGHT);
        endfunction

        // results still to come by flush; zero unless the frame's inputs are all in
        function int unsigned drain_left();
            if (row * lat_w + col >= lat_w * lat_h) return lat_w * lat_h - outs;
            return 0;
        endfunction

        function int unsigned gray_px(int r, int c);
            if (r < 0 || c < 0 || r >= int'(lat_h) || c >= int'(lat_w)) return 0;
            return gray_ring[(r % RING_ROWS) * DEF_MAX_WIDTH + c];
        endfunction

        function int unsigned weight(int d2);
            case (d2)
                0: return regs[2];
                1: return regs[3];
                2: return regs[4];
                4: return regs[5];
                5: return regs[6];
                default: return regs[7];
            endcase
        endfunction

        function int blur_px(int r, int c);
            longint unsigned acc;
            acc = 0;
            if (r < 0 || c < 0 || r >= int'(lat_h) || c >= int'(lat_w)) return 0;
            for (int dy = -2; dy <= 2; dy++)
                for (int dx = -2; dx <= 2; dx++)
                    acc += longint'(gray_px(r + dy, c + dx)) * weight(dx * dx + dy * dy);
            acc = acc >> 16;
            return (acc > 255) ? 255 : int'(acc);
        endfunction

        function int unsigned clip8(int v);
            if (v < 0) return 0;
            if (v > 255) return 255;
            return v;
        endfunction

        // next output pixel in raster order
        function void predict_word();
            int          b [3][3];
            int          r, c, sx, sy;
            int unsigned gx, gy, sq, root;
            longint unsigned lhs;
            grad_word_t  w;
            r = outs / lat_w;
            c = outs % lat_w;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    b[i][j] = blur_px(r + i - 1, c + j - 1);
            sx = (b[0][0] - b[0][2]) + 2 * (b[1][0] - b[1][2]) + (b[2][0] - b[2][2]);
            sy = (b[0][0] + 2 * b[0][1] + b[0][2]) - (b[2][0] + 2 * b[2][1] + b[2][2]);
            gx = clip8(sx);
            gy = clip8(sy);
            sq = gx * gx + gy * gy;
            root = 0;
            while ((root + 1) * (root + 1) <= sq) root++;
            w.mag = (root > 255) ? 8'd255 : root[7:0];
            lhs = longint'(gy) << 24;
            if (lhs <= longint'(TAN22_Q24) * gx) w.dir = DIR_0;
            else if (lhs <= longint'(TAN67_Q24) * gx) w.dir = DIR_45;
            else w.dir = DIR_90;
            w.lof = (outs + 1 == lat_w * lat_h);
            owed_words.push_back(w);
            outs++;
            if (outs >= lat_w * lat_h) begin
                outs = 0;
                row = 0;
                col = 0;
            end
        endfunction

        function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned total, count;
            words_in++;
            if (op == OP_FLUSH) flushes++;
            if (op == OP_PIXEL && row == 0 && col == 0 && outs == 0) begin
                lat_w = clamp_dim(regs[0], DEF_MAX_WIDTH);
                lat_h = clamp_dim(regs[1], DEF_MAX_HEIGHT);
            end
            total = lat_w * lat_h;
            count = row * lat_w + col;
            if (count < total) begin
                if (op == OP_FLUSH) return;   // flush mid-frame: ignored
                gray_ring[(row % RING_ROWS) * DEF_MAX_WIDTH + col] =
                    8'((32'(LUMA_R) * 32'(r) + 32'(LUMA_G) * 32'(g)
                        + 32'(LUMA_B) * 32'(b)) >> 16);
                col++;
                if (col >= lat_w) begin
                    col = 0;
                    row++;
                end
                count++;
                if (outs + 3 * lat_w + 3 < count) predict_word();
            end
            else if (outs < total) begin
                predict_word();               // flush, or pixel while draining
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [7:0] mag, logic [1:0] dir, logic lof);
            grad_word_t w;
            words_out++;
            if (owed_words.size() == 0) begin
                report($sformatf("unexpected word mag=%0d dir=%0d last=%0d", mag, dir, lof));
                return;
            end
            w = owed_words.pop_front();
            if (mag !== w.mag)
                report($sformatf("word %0d magnitude %0d, want %0d", words_out, mag, w.mag));
            if (dir !== w.dir)
                report($sformatf("word %0d direction %0d, want %0d", words_out, dir, w.dir));
            if (lof !== w.lof)
                report($sformatf("word %0d last_of_frame %0d, want %0d", words_out, lof, w.lof));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   opcode = OP_PIXEL;
    logic [7:0]             red = '0;
    logic [7:0]             green = '0;
    logic [7:0]             blue = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [7:0]             magnitude;
    logic [1:0]             direction;
    logic                   last_of_frame;
    logic                   write_enable = 1'b0;
    logic [INDEX_WIDTH-1:0] reg_index = '0;
    logic [CFG_WIDTH-1:0]   write_data = '0;

    gradient_scoreboard sb = new();
    int  frames_run;
    bit  pop_held;

    canny_gradient_front_end u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .empty         (empty),
        .pop           (pop),
        .magnitude     (magnitude),
        .direction     (direction),
        .last_of_frame (last_of_frame),
        .write_enable  (write_enable),
        .reg_index     (reg_index),
        .write_data    (write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // No random idling on either side in this window of input words.
    function automatic bit steady_window();
        return sb.words_in >= 600 && sb.words_in < 900;
    endfunction

    // Watchdog: a long run of cycles in which no word moves ends the test.
    int stall_cycles;
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random pops, one long hold-off so the block backs up and
    // raises full while the sender keeps offering.
    initial
    begin
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (!pop_held && sb.words_out >= 150) begin
                pop_held = 1'b1;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                @(negedge clk);
            end
            pop = steady_window() || ($urandom_range(99) >= 25);
            @(posedge clk);
            if (pop && !empty) sb.check_result(magnitude, direction, last_of_frame);
        end
    end

    // One input word; returns after the edge that accepts it.
    task send_word(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge clk);
        while (!steady_window() && $urandom_range(99) < 25) begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        opcode = op;
        red = r;
        green = g;
        blue = b;
        do @(posedge clk); while (full);
        sb.note_input(op, r, g, b);
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task send_pixel();
        send_word(OP_PIXEL, rand_channel(), rand_channel(), rand_channel());
    endtask

    task send_flush();
        // channels are don't-care on flush; drive junk so it is exercised
        send_word(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task write_reg(logic [INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
        @(negedge clk);
        write_enable = 1'b1;
        reg_index = idx;
        write_data = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        write_enable = 1'b0;
    endtask

    // Block idle: every owed word back, and time for a stray job to finish.
    task settle();
        @(negedge clk);
        push = 1'b0;
        while (sb.owed_words.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_weights(logic [CFG_WIDTH-1:0] w);
        for (int i = REG_GAUSS_CENTER; i <= REG_GAUSS_D8; i++) write_reg(INDEX_WIDTH'(i), w);
    endtask

    // One frame at the configured size: stray flushes mid-frame (ignored),
    // then drain, with an occasional pixel standing in for a flush.
    task run_frame();
        int unsigned n;
        n = sb.frame_pixels();
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) send_flush();
            send_pixel();
        end
        while (sb.drain_left() > 0) begin
            if ($urandom_range(9) == 0) send_pixel();
            else send_flush();
        end
        if ($urandom_range(3) == 0) send_flush();   // nothing pending: no word
        frames_run++;
    endtask

    function automatic logic [CFG_WIDTH-1:0] rand_weight();
        case ($urandom_range(7))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(8000));
        endcase
    endfunction

    int random_start;

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 3x3 frame with reset weights, primaries and extremes,
        // a flush before any pixel, a pixel during drain, a flush after drain.
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_flush();
        send_word(OP_PIXEL, 8'd0,   8'd0,   8'd0);
        send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        send_word(OP_PIXEL, 8'd255, 8'd0,   8'd0);
        send_word(OP_PIXEL, 8'd0,   8'd255, 8'd0);
        send_word(OP_PIXEL, 8'd0,   8'd0,   8'd255);
        send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        send_word(OP_PIXEL, 8'd255, 8'd255, 8'd255);
        send_word(OP_PIXEL, 8'd0,   8'd0,   8'd0);
        send_word(OP_PIXEL, 8'd170, 8'd85,  8'd51);
        send_flush();
        send_word(OP_PIXEL, 8'd1, 8'd2, 8'd3);
        while (sb.drain_left() > 0) send_flush();
        send_flush();
        settle();

        // Extreme weights: blur saturates, then vanishes.
        set_weights(16'hFFFF);
        write_reg(REG_FRAME_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        run_frame();
        settle();
        set_weights(16'h0000);
        run_frame();
        settle();

        // Zero sizes clamp to 1, oversize height clamps to the maximum.
        set_weights(16'd4000);
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd0);
        run_frame();
        settle();
        write_reg(REG_FRAME_WIDTH, 16'hF801);   // upper bits dropped: width 1
        write_reg(REG_FRAME_HEIGHT, 16'h07FF);
        run_frame();
        settle();

        // Random frames, small sizes, weights reshuffled now and then.
        random_start = sb.words_in;
        while (sb.words_in - random_start < RANDOM_WORDS) begin
            if ($urandom_range(2) == 0)
                for (int i = REG_GAUSS_CENTER; i <= REG_GAUSS_D8; i++)
                    write_reg(INDEX_WIDTH'(i), rand_weight());
            if ($urandom_range(9) == 0)
                write_reg(4'($urandom_range(8, 15)), 16'($urandom));   // no such register
            write_reg(REG_FRAME_WIDTH,
                      ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
            write_reg(REG_FRAME_HEIGHT,
                      ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 8)));
            run_frame();
            settle();
        end

        $display("Covered %0d frames: %0d input words (%0d flushes), %0d gradient words.",
                  frames_run, sb.words_in, sb.flushes, sb.words_out);
        $display("Extremes of weights and frame size, ignored flushes and drain-time pixels.");
        if (sb.errors == 0 && sb.owed_words.size() == 0) begin
            $display("Test completed successfully");
        end
        else begin
            $display("%0d mismatches, %0d words never arrived",
                     sb.errors, sb.owed_words.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
